// ===== sv/mavf_pkg.sv =====
package mavf_pkg;

   // Width of the window register and of every window-sized count.
   localparam int CFG_WIDTH = 9;

   typedef logic [CFG_WIDTH-1:0] cfg_width_type;

   localparam cfg_width_type WINDOW_RESET = cfg_width_type'(1);

endpackage

// ===== sv/moving_average_filter_core.sv =====
// A request passes through the front end's update state, the queue, the divider's divide
// and done states and the output register on its way to the result ports.
// The front end takes no new request until the last one is committed; the bit-serial divider
// delivers each average before it takes another sum, with a two-entry queue in between.
// Reset is synchronous and active high: window width 1, running sum, fill count and write
// pointer cleared; the sample history is not cleared and needs no clearing pass.
module moving_average_filter_core #(
   parameter int WINDOW_MAX   = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_value,
   input  logic                           req_series_start,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_average_value,
   input  logic                           csr_write_enable,
   input  mavf_pkg::cfg_width_type        csr_write_data
);

   localparam int SUM_WIDTH = SAMPLE_WIDTH + $clog2(WINDOW_MAX);
   localparam int Q_WIDTH   = SUM_WIDTH + mavf_pkg::CFG_WIDTH;

   logic                    q_push;
   logic                    q_full;
   logic [SUM_WIDTH-1:0]    q_push_sum;
   mavf_pkg::cfg_width_type q_push_width;
   logic                    q_pop;
   logic                    q_empty;
   logic [Q_WIDTH-1:0]      q_pop_data;

   mavf_front #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample_value (req_sample_value),
      .req_series_start (req_series_start),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_push           (q_push),
      .q_full           (q_full),
      .q_sum            (q_push_sum),
      .q_width          (q_push_width)
   );

   mavf_queue #(
      .DATA_WIDTH (Q_WIDTH),
      .DEPTH      (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data ({q_push_sum, q_push_width}),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   mavf_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_sum             (q_pop_data[Q_WIDTH-1:mavf_pkg::CFG_WIDTH]),
      .q_width           (q_pop_data[mavf_pkg::CFG_WIDTH-1:0]),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_average_value (rsp_average_value)
   );

endmodule

// ===== sv/mavf_front.sv =====
module mavf_front #(
   parameter int WINDOW_MAX   = 256,
   parameter int SAMPLE_WIDTH = 32,
   parameter int SUM_WIDTH    = 40
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_value,
   input  logic                    req_series_start,
   input  logic                    csr_write_enable,
   input  mavf_pkg::cfg_width_type csr_write_data,
   output logic                    q_push,
   input  logic                    q_full,
   output logic [SUM_WIDTH-1:0]    q_sum,
   output mavf_pkg::cfg_width_type q_width
);

   localparam int CW    = mavf_pkg::CFG_WIDTH;
   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int EXT_W = ((PTR_W > CW) ? PTR_W : CW) + 2;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   mavf_pkg::cfg_width_type window_ff, window_in;
   mavf_pkg::cfg_width_type count_ff, count_in;
   logic [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [PTR_W-1:0]        wptr_ff, wptr_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                    evict_ff, evict_in;
   logic                    emit_ff, emit_in;
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic [SAMPLE_WIDTH-1:0] history_ff [WINDOW_MAX];

   mavf_pkg::cfg_width_type eff_width;
   mavf_pkg::cfg_width_type count_base;
   logic [SUM_WIDTH-1:0]    sum_base;
   logic [EXT_W-1:0]        addr_ext;
   logic [PTR_W-1:0]        rd_addr;
   logic [SUM_WIDTH:0]      sum_ext, old_ext, smp_ext, new_sum;
   logic                    accept;
   logic                    commit;

   always_comb begin
      priority if (window_ff == '0) begin
         eff_width = mavf_pkg::cfg_width_type'(1);
      end else if (int'(window_ff) > WINDOW_MAX) begin
         eff_width = mavf_pkg::cfg_width_type'(WINDOW_MAX);
      end else begin
         eff_width = window_ff;
      end
   end

   // The oldest sample in the window sits eff_width entries behind the write pointer.
   assign addr_ext = EXT_W'(wptr_ff) + EXT_W'(WINDOW_MAX) - EXT_W'(eff_width);
   assign rd_addr  = (addr_ext >= EXT_W'(WINDOW_MAX)) ?
                     PTR_W'(addr_ext - EXT_W'(WINDOW_MAX)) : PTR_W'(addr_ext);

   assign req_full = (state_ff != ST_IDLE);
   assign accept   = req_push && !req_full;

   assign count_base = req_series_start ? '0 : count_ff;
   assign sum_base   = req_series_start ? '0 : sum_ff;

   assign sum_ext = {sum_ff[SUM_WIDTH-1], sum_ff};
   assign old_ext = evict_ff ?
                    {{(SUM_WIDTH+1-SAMPLE_WIDTH){rd_data_ff[SAMPLE_WIDTH-1]}}, rd_data_ff} : '0;
   assign smp_ext = {{(SUM_WIDTH+1-SAMPLE_WIDTH){sample_ff[SAMPLE_WIDTH-1]}}, sample_ff};
   assign new_sum = sum_ext - old_ext + smp_ext;

   // A request that yields no average never waits on the queue.
   assign commit = (state_ff == ST_UPDATE) && !(emit_ff && q_full);

   assign q_push  = commit && emit_ff;
   assign q_sum   = new_sum[SUM_WIDTH-1:0];
   assign q_width = eff_width;

   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      wptr_in   = wptr_ff;
      sample_in = sample_ff;
      evict_in  = evict_ff;
      emit_in   = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample_value;
               sum_in    = sum_base;
               evict_in  = (count_base >= eff_width);
               emit_in   = evict_in || ((count_base + mavf_pkg::cfg_width_type'(1)) >= eff_width);
               count_in  = evict_in ? count_base : count_base + mavf_pkg::cfg_width_type'(1);
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               sum_in   = new_sum[SUM_WIDTH-1:0];
               wptr_in  = (wptr_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : wptr_ff + PTR_W'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         window_in = csr_write_data;
         sum_in    = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         window_ff <= mavf_pkg::WINDOW_RESET;
         count_ff  <= '0;
         sum_ff    <= '0;
         wptr_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         window_ff <= window_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         wptr_ff   <= wptr_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      evict_ff  <= evict_in;
      emit_ff   <= emit_in;
   end

   // The read of the evicted sample is issued as the request is taken, before its own write.
   always_ff @(posedge clock) begin
      rd_data_ff <= history_ff[rd_addr];
      if (commit) begin
         history_ff[wptr_ff] <= sample_ff;
      end
   end

`ifndef ASSERT_OFF
   a_count_within_window: assert property (@(posedge clock) disable iff (reset)
      count_ff <= eff_width)
      else $error("fill count exceeds the window width");
`endif

endmodule

// ===== sv/mavf_queue.sv =====
module mavf_queue #(
   parameter int DATA_WIDTH = 49,
   parameter int DEPTH      = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic                  pop,
   output logic                  empty,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/mavf_back.sv =====
module mavf_back #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int SUM_WIDTH    = 40
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic [SUM_WIDTH-1:0]    q_sum,
   input  mavf_pkg::cfg_width_type q_width,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [SAMPLE_WIDTH-1:0] rsp_average_value
);

   localparam int CW    = mavf_pkg::CFG_WIDTH;
   localparam int CNT_W = $clog2(SUM_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic                    negative_ff, negative_in;
   logic [SUM_WIDTH-1:0]    quot_ff, quot_in;
   mavf_pkg::cfg_width_type rem_ff, rem_in;
   mavf_pkg::cfg_width_type divisor_ff, divisor_in;
   logic [CNT_W-1:0]        step_ff, step_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_WIDTH-1:0] out_value_ff, out_value_in;

   logic [CW:0]             shifted;
   logic [CW:0]             trial;
   logic                    fits;
   logic [SAMPLE_WIDTH-1:0] quot_low;
   logic                    deliver;

   // Restoring division on the magnitude, one quotient bit per cycle.
   assign shifted  = {rem_ff, quot_ff[SUM_WIDTH-1]};
   assign trial    = shifted - {1'b0, divisor_ff};
   assign fits     = (shifted >= {1'b0, divisor_ff});
   assign quot_low = quot_ff[SAMPLE_WIDTH-1:0];

   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;
   assign deliver = (state_ff == ST_DONE) && (!out_valid_ff || rsp_pop);

   assign rsp_empty         = !out_valid_ff;
   assign rsp_average_value = out_value_ff;

   always_comb begin
      state_in     = state_ff;
      negative_in  = negative_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      out_value_in = out_value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               negative_in = q_sum[SUM_WIDTH-1];
               quot_in     = q_sum[SUM_WIDTH-1] ? ('0 - q_sum) : q_sum;
               rem_in      = '0;
               divisor_in  = q_width;
               step_in     = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = fits ? trial[CW-1:0] : shifted[CW-1:0];
            quot_in = {quot_ff[SUM_WIDTH-2:0], fits};
            step_in = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(SUM_WIDTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (deliver) begin
               // Negating the floored magnitude gives truncation toward zero.
               out_value_in = negative_ff ? (SAMPLE_WIDTH'(0) - quot_low) : quot_low;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = deliver || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      negative_ff  <= negative_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
      out_value_ff <= out_value_in;
   end

`ifndef ASSERT_OFF
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (divisor_ff != '0))
      else $error("division started with a zero window width");
`endif

`ifndef ASSERT_OFF
   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < divisor_ff))
      else $error("partial remainder is not below the divisor");
`endif

`ifndef ASSERT_OFF
   a_result_from_divider: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a finished division");
`endif

endmodule
